// File: rtl/core/sorted_array_insert_delete_macros.svh
// Assertion macros for the checker file of the sorted list block.
`ifndef SORTED_ARRAY_INSERT_DELETE_MACROS_SVH
`define SORTED_ARRAY_INSERT_DELETE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SAI_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SAI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/sai_pkg.sv
package sai_pkg;

    typedef logic signed [31:0] value_t;
    typedef logic [1:0]         req_t;
    typedef logic [1:0]         status_t;
    typedef logic [5:0]         index_t;
    typedef logic [6:0]         count_t;

    localparam req_t REQ_INSERT = 2'd0;
    localparam req_t REQ_DELETE = 2'd1;
    localparam req_t REQ_READ   = 2'd2;

    localparam status_t ST_DONE   = 2'd0;
    localparam status_t ST_FULL   = 2'd1;
    localparam status_t ST_BADIDX = 2'd2;

    localparam count_t CAP_RESET = 7'd64;

    // Command broadcast from the control logic to every cell of the row.
    typedef struct packed {
        logic   ins;
        logic   del;
        value_t value;
    } cell_ctl_t;

endpackage

// File: rtl/core/sai_if.sv
interface sai_req_if;
    logic            valid;
    logic            ready;
    sai_pkg::req_t   req_type;
    sai_pkg::value_t value;
    sai_pkg::index_t index;

    modport source (output valid, output req_type, output value, output index, input ready);
    modport sink   (input valid, input req_type, input value, input index, output ready);
endinterface

interface sai_rsp_if;
    logic               valid;
    logic               ready;
    sai_pkg::status_t   status;
    sai_pkg::value_t    read_value;
    sai_pkg::count_t    entry_count;

    modport source (output valid, output status, output read_value, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_value, input entry_count,
                    output ready);
endinterface

// File: rtl/core/sai_cell.sv
module sai_cell
(
    input  logic              clk,
    input  sai_pkg::cell_ctl_t ctl,
    input  logic              occupied,
    input  logic              at_end,
    input  logic              del_here,
    input  logic              left_take,
    input  sai_pkg::value_t   left_entry,
    input  sai_pkg::value_t   right_entry,
    output logic              take,
    output sai_pkg::value_t   entry
);

    sai_pkg::value_t entry_reg;
    sai_pkg::value_t entry_next;

    // A cell takes part in an insert when it holds a larger value, or when it is
    // the first free cell. Sorted order makes the takers a contiguous run.
    assign take  = ctl.ins & (occupied ? (entry_reg > ctl.value) : at_end);
    assign entry = entry_reg;

    always_comb
    begin
        entry_next = entry_reg;
        if (take)
        begin
            entry_next = left_take ? left_entry : ctl.value;
        end
        else if (ctl.del && del_here)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule

// File: rtl/core/sorted_array_insert_delete.sv
// Channel   | Dir | Payload                                  | Handshake
// request   | in  | req_type, value, index                   | valid/ready
// result    | out | status, read_value, entry_count          | valid/ready
// capacity  | in  | capacity_wdata (7 bits)                  | capacity_we
//
// One request word is taken per cycle while the output register is free; its
// result word is in the output register in the following cycle. Every cell of
// the row compares and shifts in the cycle the word is taken, so the row itself
// never stalls the request side. A request is taken whenever the output register
// is empty or being drained. Reset clears the count and sets the capacity limit
// to 64; stored values are not cleared and are never read before they are written.
module sorted_array_insert_delete
#(
    parameter int DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    sai_req_if.sink             request,
    sai_rsp_if.source           result,
    input  logic                capacity_we,
    input  sai_pkg::count_t     capacity_wdata
);

    // Count needs to hold DEPTH itself. Comparisons run in a common width that
    // also covers the 7-bit capacity and the 6-bit index.
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    sai_pkg::count_t   cap_reg;

    logic              out_valid_reg;
    sai_pkg::status_t  status_reg;
    sai_pkg::status_t  status_next;
    sai_pkg::value_t   rdata_reg;
    sai_pkg::value_t   rdata_next;
    sai_pkg::count_t   ecount_reg;

    logic              accept;
    logic              full;
    logic              idx_ok;
    logic [CW-1:0]     cnt_w;
    logic [CW-1:0]     idx_w;
    logic              do_ins;
    logic              do_del;
    sai_pkg::value_t   rd_mux;

    sai_pkg::cell_ctl_t ctl;
    logic              take     [DEPTH];
    sai_pkg::value_t   entry    [DEPTH];
    logic              occupied [DEPTH];
    logic              at_end   [DEPTH];
    logic              del_here [DEPTH];

    // The output register frees itself in the same cycle it is drained.
    assign request.ready = !out_valid_reg || result.ready;
    assign accept        = request.valid && request.ready;

    assign cnt_w  = CW'(count_reg);
    assign idx_w  = CW'(request.index);
    assign full   = (cnt_w >= CW'(cap_reg)) || (cnt_w >= CW'(DEPTH));
    assign idx_ok = idx_w < cnt_w;

    // Request decode: picks the cell command and the result fields.
    always_comb
    begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        status_next = sai_pkg::ST_DONE;
        rdata_next  = '0;
        count_next  = count_reg;
        unique case (request.req_type)
            sai_pkg::REQ_INSERT:
            begin
                if (full)
                begin
                    status_next = sai_pkg::ST_FULL;
                end
                else
                begin
                    do_ins     = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            sai_pkg::REQ_DELETE:
            begin
                if (idx_ok)
                begin
                    do_del     = 1'b1;
                    count_next = count_reg - 1'b1;
                end
                else
                begin
                    status_next = sai_pkg::ST_BADIDX;
                end
            end
            sai_pkg::REQ_READ:
            begin
                if (idx_ok)
                begin
                    rdata_next = rd_mux;
                end
                else
                begin
                    status_next = sai_pkg::ST_BADIDX;
                end
            end
            default:
            begin
                // The unused request code leaves everything as it is.
                status_next = sai_pkg::ST_DONE;
            end
        endcase
    end

    assign ctl.ins   = accept && do_ins;
    assign ctl.del   = accept && do_del;
    assign ctl.value = request.value;

    // The read port is a one-hot select across the row of cells.
    always_comb
    begin
        rd_mux = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (idx_w == CW'(i))
            begin
                rd_mux = rd_mux | entry[i];
            end
        end
    end

    // The row of cells. Each cell sees its left neighbor for inserts and its
    // right neighbor for deletes; the last cell keeps its own value on delete.
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        sai_pkg::value_t right_in;
        sai_pkg::value_t left_in;
        logic            left_tk;

        assign occupied[i] = CW'(i) < cnt_w;
        assign at_end[i]   = CW'(i) == cnt_w;
        assign del_here[i] = CW'(i) >= idx_w;

        if (i == 0)
        begin : g_first
            assign left_tk = 1'b0;
            assign left_in = request.value;
        end
        else
        begin : g_mid
            assign left_tk = take[i-1];
            assign left_in = entry[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_in = entry[i];
        end
        else
        begin : g_inner
            assign right_in = entry[i+1];
        end

        sai_cell u_cell
        (
            .clk         (clk),
            .ctl         (ctl),
            .occupied    (occupied[i]),
            .at_end      (at_end[i]),
            .del_here    (del_here[i]),
            .left_take   (left_tk),
            .left_entry  (left_in),
            .right_entry (right_in),
            .take        (take[i]),
            .entry       (entry[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            cap_reg       <= sai_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (capacity_we)
            begin
                cap_reg <= capacity_wdata;
            end
            if (accept)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload is loaded only when a request word is taken.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            rdata_reg  <= rdata_next;
            ecount_reg <= 7'(count_next);
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = status_reg;
    assign result.read_value  = rdata_reg;
    assign result.entry_count = ecount_reg;

endmodule

// File: rtl/core/sai_checker.sv
`include "sorted_array_insert_delete_macros.svh"

module sai_checker
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input sai_pkg::status_t status,
    input sai_pkg::value_t  read_value
);

    `SAI_ASSERT_NEXT(a_word_gives_result, clk, rst_n, in_valid && in_ready, out_valid,
        "accepted word did not produce a result")
    `SAI_ASSERT_IMPLY(a_status_legal, clk, rst_n, out_valid,
        (status == sai_pkg::ST_DONE) || (status == sai_pkg::ST_FULL) ||
        (status == sai_pkg::ST_BADIDX), "illegal status code")
    `SAI_ASSERT_IMPLY(a_fail_reads_zero, clk, rst_n,
        out_valid && (status != sai_pkg::ST_DONE), read_value == '0,
        "failed request returned nonzero data")
    `SAI_ASSERT_NEXT(a_result_held, clk, rst_n, out_valid && !out_ready, out_valid,
        "result dropped while stalled")

endmodule

bind sorted_array_insert_delete sai_checker u_sai_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (request.valid),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .status     (result.status),
    .read_value (result.read_value)
);

// File: tb/tb_top.sv
module tb_top;

    // Row depth of the instance below; the block is built with its default.
    localparam int DEPTH = 64;

    // The fourth request code has no meaning. The block answers it with a done
    // status and leaves the list alone.
    localparam sai_pkg::req_t REQ_UNUSED = 2'd3;

    localparam sai_pkg::value_t VALUE_MAX = 32'sh7FFF_FFFF;
    localparam sai_pkg::value_t VALUE_MIN = 32'sh8000_0000;

    // At this many accepted request words, the result side stops taking words
    // for a long stretch. The output register then fills and the request side
    // has to stall.
    localparam int HOLD_AT  = 370;
    localparam int HOLD_LEN = 300;

    typedef struct {
        sai_pkg::req_t   kind;
        sai_pkg::value_t value;
        sai_pkg::index_t index;
    } request_word_t;

    typedef struct {
        sai_pkg::status_t status;
        sai_pkg::value_t  read_value;
        sai_pkg::count_t  entry_count;
    } result_word_t;

    logic            clk;
    logic            rst_n;
    logic            capacity_we;
    sai_pkg::count_t capacity_wdata;

    sai_req_if req_if ();
    sai_rsp_if rsp_if ();

    sorted_array_insert_delete u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .request        (req_if),
        .result         (rsp_if),
        .capacity_we    (capacity_we),
        .capacity_wdata (capacity_wdata)
    );

    // Shadow copy of the sorted list and of the capacity register. It is
    // advanced once for every request word that the block accepts.
    sai_pkg::value_t list_vals [DEPTH];
    int              list_len = 0;
    sai_pkg::count_t capacity_shadow = sai_pkg::CAP_RESET;

    request_word_t request_queue [$];
    result_word_t  awaited_results [$];
    request_word_t offered;

    int  send_idle_pct = 33;
    int  recv_idle_pct = 33;
    int  sent_count = 0;
    int  hold_left = 0;
    bit  hold_taken = 1'b0;
    int  mismatch_count = 0;

    initial begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Computes the result word that one request causes and updates the shadow
    // list. Ties go after all equal values already held. A capacity written
    // above the row depth counts as the row depth.
    function automatic result_word_t apply_request(request_word_t w);
        result_word_t r;
        int           limit;
        int           pos;
        r.status     = sai_pkg::ST_DONE;
        r.read_value = '0;
        limit = (int'(capacity_shadow) < DEPTH) ? int'(capacity_shadow) : DEPTH;
        case (w.kind)
            sai_pkg::REQ_INSERT:
            begin
                if (list_len >= limit)
                begin
                    r.status = sai_pkg::ST_FULL;
                end
                else
                begin
                    pos = 0;
                    while (pos < list_len && list_vals[pos] <= w.value)
                        pos++;
                    for (int k = list_len; k > pos; k--)
                        list_vals[k] = list_vals[k - 1];
                    list_vals[pos] = w.value;
                    list_len++;
                end
            end
            sai_pkg::REQ_DELETE:
            begin
                if (int'(w.index) >= list_len)
                begin
                    r.status = sai_pkg::ST_BADIDX;
                end
                else
                begin
                    for (int k = int'(w.index); k + 1 < list_len; k++)
                        list_vals[k] = list_vals[k + 1];
                    list_len--;
                end
            end
            sai_pkg::REQ_READ:
            begin
                if (int'(w.index) < list_len)
                    r.read_value = list_vals[w.index];
                else
                    r.status = sai_pkg::ST_BADIDX;
            end
            default:
            begin
                // The unused code changes nothing.
            end
        endcase
        r.entry_count = sai_pkg::count_t'(list_len);
        return r;
    endfunction

    // Request driver. A new word is put on the channel only when the slot is
    // free, that is when nothing is offered or the offered word is being taken
    // at this edge. Otherwise valid and the payload are held as they are.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            sent_count   <= 0;
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                awaited_results.push_back(apply_request(offered));
                sent_count <= sent_count + 1;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (request_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    offered = request_queue.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.req_type <= offered.kind;
                    req_if.value    <= offered.value;
                    req_if.index    <= offered.index;
                end
                else
                begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off of the result side, counted down in cycles. It starts once,
    // in the middle of a phase, while the request side still has words queued.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            hold_left  <= 0;
            hold_taken <= 1'b0;
        end
        else if (!hold_taken && sent_count == HOLD_AT)
        begin
            hold_left  <= HOLD_LEN;
            hold_taken <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    // Result monitor. Every word taken is checked field by field against the
    // oldest expected word. Ready is dropped at random and during the hold.
    always @(posedge clk)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $display("%0t: result word with none expected: status %0d, value %0d, count %0d",
                             $time, rsp_if.status, rsp_if.read_value, rsp_if.entry_count);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, rsp_if.status);
                        mismatch_count++;
                    end
                    if (rsp_if.read_value !== want.read_value)
                    begin
                        $display("%0t: read_value mismatch: expected %0d, actual %0d",
                                 $time, want.read_value, rsp_if.read_value);
                        mismatch_count++;
                    end
                    if (rsp_if.entry_count !== want.entry_count)
                    begin
                        $display("%0t: entry_count mismatch: expected %0d, actual %0d",
                                 $time, want.entry_count, rsp_if.entry_count);
                        mismatch_count++;
                    end
                end
            end
            rsp_if.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_request(sai_pkg::req_t kind, sai_pkg::value_t v, sai_pkg::index_t i);
        request_word_t w;
        w.kind  = kind;
        w.value = v;
        w.index = i;
        request_queue.push_back(w);
    endtask

    // Blocks until every queued word has been accepted and every expected
    // result has arrived, then lets a few more cycles pass. Each request has
    // exactly one result, so the block is idle at that point.
    task automatic wait_until_idle();
        while (request_queue.size() != 0 || req_if.valid || awaited_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes the capacity register while the block is idle. The next words are
    // queued only at the following falling edge.
    task automatic write_capacity(sai_pkg::count_t v);
        @(posedge clk);
        capacity_we    <= 1'b1;
        capacity_wdata <= v;
        @(posedge clk);
        capacity_we     <= 1'b0;
        capacity_shadow = v;
        @(negedge clk);
    endtask

    // Values come from three pools: a narrow band around zero so that ties are
    // frequent, the two extremes, and the whole range.
    function automatic sai_pkg::value_t pick_value();
        case ($urandom_range(3))
            0:       return sai_pkg::value_t'($urandom_range(8)) - 4;
            1:       return $urandom_range(1) ? VALUE_MAX : VALUE_MIN;
            default: return sai_pkg::value_t'($urandom);
        endcase
    endfunction

    // Queues one phase of random words. Indexes are mostly low so that many
    // deletes and reads land inside the list; the rest spans the whole field.
    task automatic queue_random_phase(int n, int ins_pct, int del_pct);
        int              r;
        sai_pkg::req_t   kind;
        sai_pkg::index_t idx;
        for (int i = 0; i < n; i++)
        begin
            r = $urandom_range(99);
            if (r < 3)
                kind = REQ_UNUSED;
            else if (r < 3 + ins_pct)
                kind = sai_pkg::REQ_INSERT;
            else if (r < 3 + ins_pct + del_pct)
                kind = sai_pkg::REQ_DELETE;
            else
                kind = sai_pkg::REQ_READ;
            if ($urandom_range(1) == 0)
                idx = sai_pkg::index_t'($urandom_range(15));
            else
                idx = sai_pkg::index_t'($urandom_range(63));
            push_request(kind, pick_value(), idx);
        end
    endtask

    initial begin
        rst_n           = 1'b0;
        capacity_we     = 1'b0;
        capacity_wdata  = sai_pkg::CAP_RESET;
        req_if.valid    = 1'b0;
        req_if.req_type = sai_pkg::REQ_READ;
        req_if.value    = '0;
        req_if.index    = '0;
        rsp_if.ready    = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Requests on the empty list, then the unused code.
        push_request(sai_pkg::REQ_READ, '0, 6'd0);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd0);
        push_request(REQ_UNUSED, sai_pkg::value_t'(-1), 6'd63);
        // Extremes and ties: the list becomes min, -1, 0, 0, max, max.
        push_request(sai_pkg::REQ_INSERT, VALUE_MAX, 6'd0);
        push_request(sai_pkg::REQ_INSERT, VALUE_MIN, 6'd63);
        push_request(sai_pkg::REQ_INSERT, '0, 6'd0);
        push_request(sai_pkg::REQ_INSERT, '0, 6'd0);
        push_request(sai_pkg::REQ_INSERT, sai_pkg::value_t'(-1), 6'd0);
        push_request(sai_pkg::REQ_INSERT, VALUE_MAX, 6'd0);
        push_request(sai_pkg::REQ_READ, '0, 6'd0);
        push_request(sai_pkg::REQ_READ, '0, 6'd5);
        // Indexes at and far above the count.
        push_request(sai_pkg::REQ_READ, '0, 6'd6);
        push_request(sai_pkg::REQ_READ, '0, 6'd63);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd63);
        // Deletes at the top, the bottom and the middle of the list.
        push_request(sai_pkg::REQ_DELETE, '0, 6'd5);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd0);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd1);
        wait_until_idle();

        // With a capacity of zero every insert is refused.
        write_capacity(7'd0);
        push_request(sai_pkg::REQ_INSERT, 32'sd5, 6'd0);
        push_request(sai_pkg::REQ_READ, '0, 6'd2);
        wait_until_idle();

        // Capacity lowered below the count: inserts stay refused until deletes
        // bring the count under the limit.
        write_capacity(7'd2);
        push_request(sai_pkg::REQ_INSERT, 32'sd1, 6'd0);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd0);
        push_request(sai_pkg::REQ_INSERT, 32'sd1, 6'd0);
        push_request(sai_pkg::REQ_DELETE, '0, 6'd0);
        push_request(sai_pkg::REQ_INSERT, 32'sd1, 6'd0);
        wait_until_idle();

        // Random phases. The first one is insert heavy so that the list fills
        // to the row depth and inserts get refused there.
        write_capacity(sai_pkg::CAP_RESET);
        queue_random_phase(230, 60, 15);
        wait_until_idle();

        // The long result hold falls inside this phase.
        write_capacity(7'd1);
        queue_random_phase(230, 45, 25);
        wait_until_idle();

        // A capacity above the row depth, with no idling on either side.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_capacity(7'd127);
        queue_random_phase(230, 60, 15);
        wait_until_idle();
        send_idle_pct = 33;
        recv_idle_pct = 33;

        write_capacity(7'd40);
        queue_random_phase(230, 45, 30);
        wait_until_idle();

        write_capacity(7'd0);
        queue_random_phase(230, 30, 45);
        wait_until_idle();

        write_capacity(sai_pkg::count_t'($urandom_range(1, 64)));
        queue_random_phase(230, 50, 25);
        wait_until_idle();

        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog. A correct run ends far earlier than this.
    initial begin
        #1000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
